// ----- rtl/mandelbrot_escape_test_defines.svh -----
// ----------------------------------------------------------------------------
// Mandelbrot escape test assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TEST_DEFINES_SVH
`define MANDELBROT_ESCAPE_TEST_DEFINES_SVH

// Same-cycle implication: the consequent must hold when the antecedent holds.
`define MBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape test package
// Fixed-point widths, result levels, controller states and control structs.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Default iteration limit.
    localparam int MAX_ITER_DEF = 32;

    // Input point format is Q4.24 in 28 bits.
    localparam int FRAC_BITS = 24;
    localparam int IN_W      = 28;

    // Carried z components reach about 24.0, so they need 30 signed bits.
    localparam int Z_W = 30;
    // Full-precision products and their sums or differences.
    localparam int P_W = 2 * Z_W;
    localparam int S_W = P_W + 1;

    // Escape limit 16.0 expressed in Q13.48.
    localparam int ESCAPE_SHIFT = 2 * FRAC_BITS + 4;

    // Result levels.
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_IN  = 8'hFF;
    localparam logic [LEVEL_W-1:0] LEVEL_OUT = 8'h00;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK
    } mbe_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic upd_en;
        logic out_load;
    } mbe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic escaped;
    } mbe_status_t;

endpackage

// ----- rtl/mbe_dp.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape test datapath
// Holds c and z, forms the three products, the escape test and the next z.
// ----------------------------------------------------------------------------
module mbe_dp
    import mbe_pkg::*;
(
    input  logic                 clk,
    input  mbe_cmd_t             cmd,
    input  logic [2*IN_W-1:0]    point,
    output mbe_status_t          status,
    output logic [LEVEL_W-1:0]   level
);

    localparam logic signed [S_W-1:0] ESC_LIMIT = S_W'(64'd1 << ESCAPE_SHIFT);

    logic signed [IN_W-1:0]  c_real_reg;
    logic signed [IN_W-1:0]  c_imag_reg;
    logic signed [Z_W-1:0]   zr_reg;
    logic signed [Z_W-1:0]   zi_reg;
    logic signed [Z_W-1:0]   zr_next;
    logic signed [Z_W-1:0]   zi_next;
    logic signed [P_W-1:0]   p_rr_reg;
    logic signed [P_W-1:0]   p_ii_reg;
    logic signed [P_W-1:0]   p_ri_reg;
    logic signed [S_W-1:0]   diff;
    logic signed [S_W-1:0]   dbl;
    logic signed [S_W-1:0]   mag;
    logic signed [S_W-1:0]   diff_sh;
    logic signed [S_W-1:0]   dbl_sh;
    logic [LEVEL_W-1:0]      level_reg;

    // Combine the registered products: magnitude of the current z and the next z.
    always_comb
    begin
        diff    = S_W'(p_rr_reg) - S_W'(p_ii_reg);
        dbl     = S_W'(p_ri_reg) <<< 1;
        mag     = S_W'(p_rr_reg) + S_W'(p_ii_reg);
        diff_sh = diff >>> FRAC_BITS;
        dbl_sh  = dbl >>> FRAC_BITS;
        zr_next = Z_W'(diff_sh) + Z_W'(c_real_reg);
        zi_next = Z_W'(dbl_sh) + Z_W'(c_imag_reg);
    end

    assign status.escaped = (mag > ESC_LIMIT);

    // Point, z, product and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_real_reg <= point[IN_W-1:0];
            c_imag_reg <= point[2*IN_W-1:IN_W];
            zr_reg     <= '0;
            zi_reg     <= '0;
        end
        else if (cmd.upd_en)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
        if (cmd.mul_en)
        begin
            p_rr_reg <= zr_reg * zr_reg;
            p_ii_reg <= zi_reg * zi_reg;
            p_ri_reg <= zr_reg * zi_reg;
        end
        if (cmd.out_load)
        begin
            level_reg <= status.escaped ? LEVEL_OUT : LEVEL_IN;
        end
    end

    assign level = level_reg;

endmodule

// ----- rtl/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape test controller
// Sequences load, multiply and check rounds and owns the output valid flag.
// ----------------------------------------------------------------------------
module mbe_ctrl
    import mbe_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  mbe_status_t  status,
    output mbe_cmd_t     cmd
);

    localparam int CNT_W = $clog2(MAX_ITER + 1);

    mbe_state_t        state_reg;
    mbe_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              done;
    logic              out_free;

    // The point is finished when it escaped or every step has been checked.
    assign done     = status.escaped || (cnt_reg == CNT_W'(MAX_ITER));
    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!done)
                begin
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.upd_en   = !done;
                cmd.out_load = done && out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Step counter and output valid flag.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.upd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/mandelbrot_escape_test.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape test top level
// One point is in work at a time: once taken, multiply and check rounds run
// until it escapes or all MAX_ITER steps are checked, and a stalled output
// holds the check; the output register frees the input side early.
// Reset: rst_n clears the controller and the output valid flag at once.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_test_defines.svh"

module mandelbrot_escape_test
    import mbe_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*IN_W-1:0]   s_tdata,   // c_real [27:0], c_imag [55:28]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [LEVEL_W-1:0]  m_tdata    // pixel_level [7:0]
);

    mbe_cmd_t     cmd;
    mbe_status_t  status;

    // Controller.
    mbe_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    mbe_dp u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .point  (s_tdata),
        .status (status),
        .level  (m_tdata)
    );

    // A point in work blocks the input for at least the following cycle.
    `MBE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input ready right after accepting a word")
    // A result cannot appear in the cycle after a word is taken.
    `MBE_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid),
        "result raised immediately after accept")
    // A valid result is one of the two levels.
    `MBE_ASSERT_SAME(a_level_code, m_tvalid,
        m_tdata == LEVEL_IN || m_tdata == LEVEL_OUT,
        "result level is neither bounded nor escaped code")

endmodule

// ----- tb/mandelbrot_escape_test_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape test checker
// Watches both stream channels of the block. Each accepted input word is run
// through an independent escape-time computation, and the expected level is
// queued. Each accepted output word is compared with the oldest queued level.
// ----------------------------------------------------------------------------
module mandelbrot_escape_test_checker
    import mbe_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [2*IN_W-1:0]   s_tdata,   // c_real [27:0], c_imag [55:28]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [LEVEL_W-1:0]  m_tdata,   // pixel_level [7:0]
    output int                  fail_count,
    output int                  pending
);

    logic [LEVEL_W-1:0] level_q[$];
    int                 errors = 0;

    assign fail_count = errors;

    // Iterate z = z*z + c from zero with exact Q4.24 products, flooring each
    // rescale, and stop as soon as |z|^2 exceeds 16.0.
    function automatic logic [LEVEL_W-1:0] escape_level(
        input logic signed [IN_W-1:0] cr,
        input logic signed [IN_W-1:0] ci
    );
        longint zr;
        longint zi;
        longint re;
        longint im;
        longint c_re;
        longint c_im;
        longint limit_q48;
        c_re      = cr;
        c_im      = ci;
        zr        = 0;
        zi        = 0;
        limit_q48 = 64'sd1 << ESCAPE_SHIFT;
        for (int step = 0; step < MAX_ITER; step++)
        begin
            re = ((zr * zr - zi * zi) >>> FRAC_BITS) + c_re;
            im = ((2 * zr * zi) >>> FRAC_BITS) + c_im;
            if (re * re + im * im > limit_q48)
                return LEVEL_OUT;
            zr = re;
            zi = im;
        end
        return LEVEL_IN;
    endfunction

    // Queue expectations on input words and match them against output words.
    always @(posedge clk or negedge rst_n)
    begin
        logic [LEVEL_W-1:0] want;
        if (!rst_n)
        begin
            level_q.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                level_q.push_back(escape_level(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W]));
            if (m_tvalid && m_tready)
            begin
                if (level_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: output word %0d with no point outstanding",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want = level_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: pixel_level expected %0d, got %0d",
                                     $realtime, want, m_tdata);
                    end
                end
            end
            pending <= level_q.size();
        end
    end

endmodule

// ----- tb/mandelbrot_escape_test_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape test testbench
// Drives directed and random complex points into the block with random gaps
// on both sides, a long output stall and a drain pause; a checker module
// predicts every pixel level and reports mismatches.
// ----------------------------------------------------------------------------
module mandelbrot_escape_test_tb;
    import mbe_pkg::*;

    localparam int N_ITER  = MAX_ITER_DEF;
    localparam int LATENCY = 2 * (N_ITER + 1);
    localparam int Q_ONE   = 1 << FRAC_BITS;
    localparam int IDLE_PCT = 38;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*IN_W-1:0]   s_tdata  = '0;   // c_real [27:0], c_imag [55:28]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [LEVEL_W-1:0]  m_tdata;         // pixel_level [7:0]

    int fail_count;
    int pending;

    // Receiver controls, set by the stimulus and consumed by the receiver.
    bit rx_idle_on   = 1'b1;
    int rx_hold_left = 0;

    always #5 clk = ~clk;

    mandelbrot_escape_test #(.MAX_ITER(N_ITER)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mandelbrot_escape_test_checker #(.MAX_ITER(N_ITER)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one point, with optional random gaps first, and hold it until taken.
    task automatic offer_point(input int cr, input int ci, input bit gaps);
        while (gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ci[IN_W-1:0], cr[IN_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Wait until every queued level has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random points: mostly near the set boundary, the rest over wider ranges or near the origin.
    task automatic run_points(input int count, input bit gaps);
        int cr;
        int ci;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                cr = int'($urandom_range(0, 3 * Q_ONE)) - 9 * Q_ONE / 4;
                ci = int'($urandom_range(0, 3 * Q_ONE)) - 3 * Q_ONE / 2;
            end
            else if (pick < 75)
            begin
                cr = int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE;
                ci = int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE;
            end
            else if (pick < 88)
            begin
                // Any 28-bit pattern, including points far beyond 4.0.
                cr = $urandom();
                ci = $urandom();
            end
            else
            begin
                cr = int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4;
                ci = int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4;
            end
            offer_point(cr, ci, gaps);
        end
    endtask

    // Receiver: random stalls, plus a counted hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("mandelbrot_escape_test_tb: FAIL");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points: origin, cusp, tip, exact |z| = 4 cases, extremes.
        offer_point(0, 0, 1'b1);
        offer_point(Q_ONE / 4, 0, 1'b1);
        offer_point(-2 * Q_ONE, 0, 1'b1);
        offer_point(4 * Q_ONE, 0, 1'b1);
        offer_point(-4 * Q_ONE, 0, 1'b1);
        offer_point(0, 4 * Q_ONE, 1'b1);
        offer_point(0, -4 * Q_ONE, 1'b1);
        offer_point(4 * Q_ONE + 1, 0, 1'b1);
        offer_point(-(1 << 27), -(1 << 27), 1'b1);
        offer_point((1 << 27) - 1, (1 << 27) - 1, 1'b1);
        offer_point(-(1 << 27), (1 << 27) - 1, 1'b1);
        offer_point((1 << 27) - 1, -(1 << 27), 1'b1);
        offer_point(0, Q_ONE, 1'b1);
        offer_point(0, -Q_ONE, 1'b1);
        offer_point(-Q_ONE, 0, 1'b1);
        offer_point(Q_ONE / 2, 0, 1'b1);
        offer_point(-3 * Q_ONE / 4, Q_ONE / 10, 1'b1);
        offer_point(Q_ONE / 4 + Q_ONE / 100, 0, 1'b1);
        offer_point(-2 * Q_ONE - 1, 0, 1'b1);
        offer_point(-7 * Q_ONE / 4, 0, 1'b1);
        offer_point(-Q_ONE / 10, 13 * Q_ONE / 20, 1'b1);
        offer_point(-1, -1, 1'b1);

        // Random gaps on both sides.
        run_points(200, 1'b1);

        // Long output stall while the sender keeps offering words.
        rx_hold_left = 400;
        run_points(20, 1'b0);

        // Pause the sender until every result is back.
        wait_drained();

        // Long stretch with no idling on either side.
        rx_idle_on = 1'b0;
        run_points(150, 1'b0);
        rx_idle_on = 1'b1;

        run_points(230, 1'b1);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("mandelbrot_escape_test_tb: PASS");
        else
            $display("mandelbrot_escape_test_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_dp.sv
rtl/mbe_ctrl.sv
rtl/mandelbrot_escape_test.sv
tb/mandelbrot_escape_test_checker.sv
tb/mandelbrot_escape_test_tb.sv
